// ===== sv/axis_angle_rotation_matrix_defines.svh =====
// Assertion macros for the rotation matrix block.
`ifndef AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH
`define AXIS_ANGLE_ROTATION_MATRIX_DEFINES_SVH
`ifndef SYNTH
`define ARM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ARM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ARM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ARM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== sv/aarm_pkg.sv =====
package aarm_pkg;
   localparam int TableLen = 32;
   localparam logic signed [33:0] InvGain = 34'sd652032874;

   function automatic logic signed [33:0] atan_turn(input int idx);
      logic signed [33:0] t;
      begin
         unique case (idx)
            0: t = 34'sd536870912;  1: t = 34'sd316933406;
            2: t = 34'sd167458907;  3: t = 34'sd85004756;
            4: t = 34'sd42667331;   5: t = 34'sd21354465;
            6: t = 34'sd10679838;   7: t = 34'sd5340245;
            8: t = 34'sd2670163;    9: t = 34'sd1335087;
            10: t = 34'sd667544;    11: t = 34'sd333772;
            12: t = 34'sd166886;    13: t = 34'sd83443;
            14: t = 34'sd41722;     15: t = 34'sd20861;
            16: t = 34'sd10430;     17: t = 34'sd5215;
            18: t = 34'sd2608;      19: t = 34'sd1304;
            20: t = 34'sd652;       21: t = 34'sd326;
            22: t = 34'sd163;       23: t = 34'sd81;
            24: t = 34'sd41;        25: t = 34'sd20;
            26: t = 34'sd10;        27: t = 34'sd5;
            28: t = 34'sd3;         29: t = 34'sd1;
            30: t = 34'sd1;
            default: t = 34'sd0;
         endcase
         return t;
      end
   endfunction

   // Axis components and quadrant that ride along the rotator chain.
   typedef struct packed {
      logic signed [15:0] ux;
      logic signed [15:0] uy;
      logic signed [15:0] uz;
      logic [1:0]         quad;
   } side_type;

   typedef struct packed {
      logic signed [33:0] x;
      logic signed [33:0] y;
      logic signed [33:0] z;
   } rot_type;
endpackage

// ===== sv/aarm_cell.sv =====
// One CORDIC rotation with its own pipeline register and stall.
module aarm_cell
   import aarm_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_valid,
   input  rot_type  in_rot,
   input  side_type in_side,
   output logic     out_valid,
   output rot_type  out_rot,
   output side_type out_side
);
   logic     valid_ff;
   rot_type  rot_ff, rot_in;
   side_type side_ff;

   always_comb begin
      if (in_rot.z >= 0) begin
         rot_in.x = in_rot.x - (in_rot.y >>> STEP);
         rot_in.y = in_rot.y + (in_rot.x >>> STEP);
         rot_in.z = in_rot.z - atan_turn(STEP);
      end else begin
         rot_in.x = in_rot.x + (in_rot.y >>> STEP);
         rot_in.y = in_rot.y - (in_rot.x >>> STEP);
         rot_in.z = in_rot.z + atan_turn(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         rot_ff  <= rot_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rot   = rot_ff;
   assign out_side  = side_ff;
endmodule

// ===== sv/aarm_matrix.sv =====
// Rodrigues assembly: three pipeline stages after sine and cosine.
module aarm_matrix
   import aarm_pkg::*;
#(
   parameter int FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  rot_type            in_rot,
   input  side_type           in_side,
   output logic               out_valid,
   output logic [9*16-1:0]    out_mat
);
   localparam int Sh = 30 - FRAC_BITS;
   localparam logic signed [35:0] Half = 36'sd1 <<< (FRAC_BITS - 1);

   function automatic logic signed [35:0] mulr(input logic signed [35:0] a,
                                               input logic signed [35:0] b);
      logic signed [71:0] p;
      begin
         p = a * b + 72'(Half);
         return 36'(p >>> FRAC_BITS);
      end
   endfunction

   function automatic logic [15:0] sat(input logic signed [35:0] v);
      logic [15:0] r;
      begin
         if (v > 36'sd32767) r = 16'h7fff;
         else if (v < -36'sd32768) r = 16'h8000;
         else r = v[15:0];
         return r;
      end
   endfunction

   logic [2:0] valid_ff;
   logic signed [35:0] c_ff, s_ff, w_ff;
   side_type side_ff;
   logic signed [35:0] cr, sr, cq, sq;
   logic signed [35:0] xx_ff, yy_ff, zz_ff, xy_ff, xz_ff, yz_ff;
   logic signed [35:0] xs_ff, ys_ff, zs_ff, c2_ff, w2_ff;
   logic signed [35:0] dx_ff, dy_ff, dz_ff, pxy_ff, pxz_ff, pyz_ff;
   logic signed [35:0] xs3_ff, ys3_ff, zs3_ff, c3_ff;
   logic [9*16-1:0] mat_ff;
   logic signed [35:0] ux, uy, uz;

   always_comb begin
      unique case (in_side.quad)
         2'd0: begin cq = 36'(in_rot.x); sq = 36'(in_rot.y); end
         2'd1: begin cq = -36'(in_rot.y); sq = 36'(in_rot.x); end
         2'd2: begin cq = -36'(in_rot.x); sq = -36'(in_rot.y); end
         default: begin cq = 36'(in_rot.y); sq = -36'(in_rot.x); end
      endcase
      cr = (cq + (36'sd1 <<< (Sh - 1))) >>> Sh;
      sr = (sq + (36'sd1 <<< (Sh - 1))) >>> Sh;
      ux = 36'(side_ff.ux);
      uy = 36'(side_ff.uy);
      uz = 36'(side_ff.uz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[1:0], in_valid};
      end
      if (adv) begin
         // Stage 1: sine, cosine and the axis.
         c_ff    <= cr;
         s_ff    <= sr;
         w_ff    <= (36'sd1 <<< FRAC_BITS) - cr;
         side_ff <= in_side;
         // Stage 2: axis products and sine terms.
         xx_ff <= mulr(ux, ux);  yy_ff <= mulr(uy, uy);  zz_ff <= mulr(uz, uz);
         xy_ff <= mulr(ux, uy);  xz_ff <= mulr(ux, uz);  yz_ff <= mulr(uy, uz);
         xs_ff <= mulr(ux, s_ff); ys_ff <= mulr(uy, s_ff); zs_ff <= mulr(uz, s_ff);
         c2_ff <= c_ff;
         w2_ff <= w_ff;
         // Stage 3: scale by one minus cosine.
         dx_ff  <= mulr(xx_ff, w2_ff); dy_ff <= mulr(yy_ff, w2_ff);
         dz_ff  <= mulr(zz_ff, w2_ff);
         pxy_ff <= mulr(xy_ff, w2_ff); pxz_ff <= mulr(xz_ff, w2_ff);
         pyz_ff <= mulr(yz_ff, w2_ff);
         xs3_ff <= xs_ff; ys3_ff <= ys_ff; zs3_ff <= zs_ff; c3_ff <= c2_ff;
         // Stage 4: sums and saturation.
         mat_ff <= {sat(dz_ff + c3_ff), sat(pyz_ff + xs3_ff), sat(pxz_ff - ys3_ff),
                    sat(pyz_ff - xs3_ff), sat(dy_ff + c3_ff), sat(pxy_ff + zs3_ff),
                    sat(pxz_ff + ys3_ff), sat(pxy_ff - zs3_ff), sat(dx_ff + c3_ff)};
      end
   end

   logic last_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 1'b0;
      end else if (adv) begin
         last_ff <= valid_ff[2];
      end
   end

   assign out_valid = last_ff;
   assign out_mat   = mat_ff;
endmodule

// ===== sv/axis_angle_rotation_matrix.sv =====
// Throughput: one word per cycle unless stalled; a row of CORDIC rotator cells,
// one per step, followed by a four-stage multiply and sum pipeline.
// The whole pipeline stalls together while rsp_tvalid is high and rsp_tready low.
// Reset is synchronous, active high, and clears all valid flags.
`include "axis_angle_rotation_matrix_defines.svh"
module axis_angle_rotation_matrix
   import aarm_pkg::*;
#(
   parameter int FRAC_BITS    = 14,
   parameter int CORDIC_STEPS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   // axis_x, axis_y, axis_z, turn_angle
   input  logic [63:0]    req_tdata,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // r00, r01, r02, r10, r11, r12, r20, r21, r22
   output logic [143:0]   rsp_tdata
);
   localparam int Steps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   logic [31:0] ang, resid;
   logic [1:0]  quad;
   always_comb begin
      ang   = {req_tdata[63:48], 16'h0000};
      quad  = 2'((ang + 32'h2000_0000) >> 30);
      resid = ang - {quad, 30'd0};
   end

   logic     v_ch [0:Steps];
   rot_type  r_ch [0:Steps];
   side_type s_ch [0:Steps];

   assign v_ch[0]      = req_tvalid;
   assign r_ch[0].x    = InvGain;
   assign r_ch[0].y    = '0;
   assign r_ch[0].z    = 34'($signed(resid));
   assign s_ch[0].ux   = req_tdata[15:0];
   assign s_ch[0].uy   = req_tdata[31:16];
   assign s_ch[0].uz   = req_tdata[47:32];
   assign s_ch[0].quad = quad;

   for (genvar g = 0; g < Steps; g++) begin : g_cell
      aarm_cell #(.STEP(g)) u_cell (
         .clock(clock), .reset(reset), .adv(adv),
         .in_valid(v_ch[g]), .in_rot(r_ch[g]), .in_side(s_ch[g]),
         .out_valid(v_ch[g+1]), .out_rot(r_ch[g+1]), .out_side(s_ch[g+1])
      );
   end

   aarm_matrix #(.FRAC_BITS(FRAC_BITS)) u_matrix (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(v_ch[Steps]), .in_rot(r_ch[Steps]), .in_side(s_ch[Steps]),
      .out_valid(rsp_tvalid), .out_mat(rsp_tdata)
   );

   `ARM_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   `ARM_ASSERT_NEXT(a_hold_stall, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ARM_ASSERT_NEXT(a_data_stall, clock, reset, rsp_tvalid && !rsp_tready, $stable(rsp_tdata))
endmodule

// ===== verif/axis_angle_rotation_matrix_test.sv =====
module axis_angle_rotation_matrix_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS    = 14;
   localparam int CORDIC_STEPS = 16;
   localparam int LATENCY      = CORDIC_STEPS + 4;

   // Turn fraction of atan(2^-i), 2^32 units per turn.
   localparam longint ATAN_TURN [32] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};

   localparam logic [15:0] DIRECTED_ANGLES [8] = '{16'h0000, 16'h2000, 16'h4000,
      16'h8000, 16'hC000, 16'hFFFF, 16'h1FFF, 16'h6000};

   typedef struct {
      logic signed [15:0] ax, ay, az;
      logic [15:0]        angle;
   } axis_angle_type;

   class rotation_scoreboard;
      logic [143:0] pending[$];
      int           errors;

      function longint rshift(longint v, int s);
         if (s == 0) return v;
         return (v + (longint'(1) <<< (s - 1))) >>> s;
      endfunction

      function longint fmul(longint a, longint b);
         return rshift(a * b, FRAC_BITS);
      endfunction

      function logic [15:0] clip(longint v);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return v[15:0];
      endfunction

      function logic [143:0] rotation_matrix(axis_angle_type it);
         logic [31:0]  a, r;
         logic [1:0]   q;
         longint       x, y, z, nx, c, s, w, ux, uy, uz, xy, xz, yz;
         logic [143:0] m;
         a = {it.angle, 16'h0};
         q = 2'((a + 32'h2000_0000) >> 30);
         r = a - ({30'd0, q} << 30);
         z = longint'($signed(r));
         x = 652032874;
         y = 0;
         for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            if (z >= 0) begin
               nx = x - (y >>> i); y = y + (x >>> i); z -= ATAN_TURN[i];
            end else begin
               nx = x + (y >>> i); y = y - (x >>> i); z += ATAN_TURN[i];
            end
            x = nx;
         end
         unique case (q)
            2'd0: begin c = x; s = y; end
            2'd1: begin c = -y; s = x; end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
         endcase
         c = rshift(c, 30 - FRAC_BITS);
         s = rshift(s, 30 - FRAC_BITS);
         w = (longint'(1) <<< FRAC_BITS) - c;
         ux = it.ax; uy = it.ay; uz = it.az;
         xy = fmul(fmul(ux, uy), w);
         xz = fmul(fmul(ux, uz), w);
         yz = fmul(fmul(uy, uz), w);
         m[15:0]    = clip(fmul(fmul(ux, ux), w) + c);
         m[31:16]   = clip(xy - fmul(uz, s));
         m[47:32]   = clip(xz + fmul(uy, s));
         m[63:48]   = clip(xy + fmul(uz, s));
         m[79:64]   = clip(fmul(fmul(uy, uy), w) + c);
         m[95:80]   = clip(yz - fmul(ux, s));
         m[111:96]  = clip(xz - fmul(uy, s));
         m[127:112] = clip(yz + fmul(ux, s));
         m[143:128] = clip(fmul(fmul(uz, uz), w) + c);
         return m;
      endfunction

      function void note_input(axis_angle_type it);
         pending.push_back(rotation_matrix(it));
      endfunction

      function void check_matrix(logic [143:0] got);
         logic [143:0] want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected matrix word %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         for (int e = 0; e < 9; e++)
            if (got[e*16 +: 16] !== want[e*16 +: 16]) begin
               $display("%0t: entry r%0d%0d expected %0d actual %0d", $time, e / 3,
                        e % 3, $signed(want[e*16 +: 16]), $signed(got[e*16 +: 16]));
               errors++;
            end
      endfunction
   endclass

   logic          clock = 0;
   logic          reset = 1;
   logic          req_tvalid = 0;
   logic          req_tready;
   logic [63:0]   req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 0;
   logic [143:0]  rsp_tdata;

   rotation_scoreboard board = new();
   int send_idle = 0;
   int recv_idle = 0;
   bit stall_free = 0;

   axis_angle_rotation_matrix #(.FRAC_BITS(FRAC_BITS), .CORDIC_STEPS(CORDIC_STEPS)) dut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_matrix(rsp_tdata);
      if (!reset && req_tvalid && req_tready) begin
         axis_angle_type it;
         it.ax = req_tdata[15:0]; it.ay = req_tdata[31:16];
         it.az = req_tdata[47:32]; it.angle = req_tdata[63:48];
         board.note_input(it);
      end
      rsp_tready <= stall_free ? 1'b1 : ($urandom_range(99) >= recv_idle);
   end

   task automatic send_word(axis_angle_type it);
      while (!stall_free && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {it.angle, it.az, it.ay, it.ax};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_idle_word();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic axis_angle_type random_item();
      axis_angle_type it;
      logic signed [15:0] axes[3];
      int k;
      k = $urandom_range(9);
      if (k < 7) begin
         // Mostly near-unit axes along one direction with a random sign.
         foreach (axes[i]) axes[i] = 16'($signed($urandom_range(16384)) - 8192);
         axes[$urandom_range(2)] = ($urandom_range(1) ? 16'sd16384 : -16'sd16384)
                                   + 16'($signed($urandom_range(2000)) - 1000);
      end else begin
         foreach (axes[i]) axes[i] = 16'($urandom);
      end
      it.ax = axes[0]; it.ay = axes[1]; it.az = axes[2];
      it.angle = 16'($urandom);
      return it;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      axis_angle_type it;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: unit axes over quadrant edges, then extreme and non-unit axes.
      for (int i = 0; i < 8; i++) begin
         it.ax = '0; it.ay = '0; it.az = '0;
         unique case (i % 3)
            0: it.ax = 16'sd16384;
            1: it.ay = 16'sd16384;
            default: it.az = -16'sd16384;
         endcase
         it.angle = DIRECTED_ANGLES[i];
         send_word(it);
      end
      it = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h4000}; send_word(it);
      it = '{16'sh8000, 16'sh8000, 16'sh8000, 16'h8000}; send_word(it);
      it = '{16'sh8000, 16'sh7FFF, 16'sh0000, 16'hC000}; send_word(it);
      it = '{16'sh7FFF, 16'sh8000, 16'sh8000, 16'h2000}; send_word(it);
      it = '{16'shFFFF, 16'sh0001, 16'shAAAA, 16'h5555}; send_word(it);
      it = '{16'sh5555, 16'shAAAA, 16'sh5555, 16'hAAAA}; send_word(it);
      it = '{16'sh0000, 16'sh0000, 16'sh0000, 16'hFFFF}; send_word(it);
      it = '{16'sh2D41, 16'sh2D41, 16'sh0000, 16'h1000}; send_word(it);
      // Hold the sender until the pipeline has drained.
      wait_drained();
      send_idle = 34; recv_idle = 45;
      repeat (170) send_word(random_item());
      send_idle_word();
      send_idle = 45; recv_idle = 34;
      repeat (170) send_word(random_item());
      send_idle_word();
      stall_free = 1;
      repeat (170) send_word(random_item());
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      if (board.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #2ms;
      $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== filelist.f =====
+incdir+sv
sv/aarm_pkg.sv
sv/aarm_cell.sv
sv/aarm_matrix.sv
sv/axis_angle_rotation_matrix.sv
verif/axis_angle_rotation_matrix_test.sv
